// ===== rtl/core/nfa_pkg.sv =====
// Shared types and constants for the next-fit arena allocator.
// Depends on nothing; nfa_store, nfa_ctrl and the top file import it.
package nfa_pkg;

   localparam int ARENA_BYTES_DEF = 4096;
   localparam int WORD_W = 16;
   localparam int ADDR_W = 17;
   localparam int CSR_W = 13;
   localparam int SIZE_W = 12;

   localparam logic [WORD_W-1:0] HDR_BYTES = 16'd8;
   localparam logic [WORD_W-1:0] FIRST_HDR = 16'd2;
   localparam logic [WORD_W-1:0] MIN_SPLIT = 16'd12;
   localparam logic [WORD_W-1:0] MARK_FREE = 16'd0;
   localparam logic [WORD_W-1:0] MARK_USED = 16'd1;
   localparam logic [CSR_W-1:0] CSR_RESET = 13'd4096;
   localparam logic [WORD_W-1:0] MIN_ARENA = 16'd16;

   typedef enum logic [1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_RESIZE = 2'd2,
      KIND_FORMAT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_NOT_FMT  = 2'd2
   } status_type;

   typedef struct packed {
      kind_type          kind;
      logic [SIZE_W-1:0] req_size;
      logic [SIZE_W-1:0] position;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SIZE_W-1:0] out_position;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] wdata;
   } mem_req_type;

   typedef enum logic [1:0] {
      CTX_ALLOC,
      CTX_FREE_NEXT,
      CTX_FREE_PREV,
      CTX_GROW
   } ctx_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_DONE,
      ST_FMT0, ST_FMT1, ST_FMT2, ST_FMT3,
      ST_V0, ST_VC, ST_VM, ST_VN, ST_BR,
      ST_R0, ST_R1, ST_R2, ST_R3, ST_R4,
      ST_A0, ST_A1, ST_A2, ST_A3,
      ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_S8,
      ST_SRET, ST_SEND,
      ST_FR0, ST_FR1, ST_FR2, ST_FR3, ST_FP0, ST_FP1, ST_FP2, ST_FE,
      ST_AB0, ST_AB1, ST_AB2, ST_AB3, ST_AB4, ST_AB5, ST_AB6
   } state_type;

endpackage

// ===== rtl/core/nfa_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module nfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/core/nfa_store.sv =====
// Arena byte store as two interleaved byte banks giving one 16-bit word per cycle.
// Accesses past the arena end read zero and write nothing. Uses nfa_pkg, nfa_ram.
module nfa_store #(
   parameter int ARENA_BYTES = nfa_pkg::ARENA_BYTES_DEF
) (
   input  logic                      clock,
   input  nfa_pkg::mem_req_type      mem_req,
   output logic [nfa_pkg::WORD_W-1:0] mem_rdata
);
   import nfa_pkg::*;

   localparam int BANK_DEPTH = ARENA_BYTES / 2;
   localparam int IDX_W = $clog2(BANK_DEPTH);

   logic [ADDR_W-1:0] addr_p1;
   logic [ADDR_W:0]   end_byte;
   logic              in_range;
   logic              we;
   logic [IDX_W-1:0]  even_idx;
   logic [IDX_W-1:0]  odd_idx;
   logic [7:0]        even_wdata;
   logic [7:0]        odd_wdata;
   logic [7:0]        even_q;
   logic [7:0]        odd_q;
   logic              odd_ff;
   logic              valid_ff;

   assign addr_p1 = mem_req.addr + ADDR_W'(1);
   assign end_byte = {1'b0, mem_req.addr} + (ADDR_W + 1)'(1);
   assign in_range = end_byte < (ADDR_W + 1)'(ARENA_BYTES);
   assign we = mem_req.we & in_range;
   assign even_idx = addr_p1[IDX_W:1];
   assign odd_idx = mem_req.addr[IDX_W:1];
   assign even_wdata = mem_req.addr[0] ? mem_req.wdata[15:8] : mem_req.wdata[7:0];
   assign odd_wdata = mem_req.addr[0] ? mem_req.wdata[7:0] : mem_req.wdata[15:8];

   nfa_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (even_idx),
      .wr_data (even_wdata),
      .rd_addr (even_idx),
      .rd_data (even_q)
   );

   nfa_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (odd_idx),
      .wr_data (odd_wdata),
      .rd_addr (odd_idx),
      .rd_data (odd_q)
   );

   always_ff @(posedge clock) begin
      odd_ff <= mem_req.addr[0];
      valid_ff <= in_range;
   end

   always_comb begin
      if (!valid_ff) begin
         mem_rdata = '0;
      end else if (odd_ff) begin
         mem_rdata = {even_q, odd_q};
      end else begin
         mem_rdata = {odd_q, even_q};
      end
   end

endmodule

// ===== rtl/core/nfa_ctrl.sv =====
// Sequencer that walks and edits block headers in the arena store to serve requests.
// Holds the rover, the formatted flag and the result register. Uses nfa_pkg.
module nfa_ctrl #(
   parameter int ARENA_BYTES = nfa_pkg::ARENA_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  nfa_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output nfa_pkg::rsp_type           rsp_data,
   input  logic [nfa_pkg::WORD_W-1:0] format_size,
   output nfa_pkg::mem_req_type       mem_req,
   input  logic [nfa_pkg::WORD_W-1:0] mem_rdata
);
   import nfa_pkg::*;

   localparam int WALK_LIMIT = ARENA_BYTES / 8 + 2;
   localparam int CNT_W = $clog2(WALK_LIMIT + 1);

   function automatic logic [ADDR_W-1:0] at(input logic [WORD_W-1:0] base,
                                            input logic [3:0] off);
      return {1'b0, base} + ADDR_W'(off);
   endfunction

   state_type         state_ff, state_in;
   ctx_type           ctx_ff, ctx_in;
   kind_type          kind_ff, kind_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] pos_ff, pos_in;
   logic [WORD_W-1:0] hdr_ff, hdr_in;
   logic [WORD_W-1:0] walk_ff, walk_in;
   logic [WORD_W-1:0] sp_ff, sp_in;
   logic [WORD_W-1:0] ab_ff, ab_in;
   logic [WORD_W-1:0] n_ff, n_in;
   logic [WORD_W-1:0] p_ff, p_in;
   logic [WORD_W-1:0] an_ff, an_in;
   logic [WORD_W-1:0] ann_ff, ann_in;
   logic [WORD_W-1:0] sz_ff, sz_in;
   logic [WORD_W-1:0] bs_ff, bs_in;
   logic [WORD_W-1:0] sn_ff, sn_in;
   logic [ADDR_W-1:0] t_ff, t_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              fit_ff, fit_in;
   logic              ok_ff, ok_in;
   logic [SIZE_W-1:0] res_ff, res_in;
   logic [WORD_W-1:0] rover_ff, rover_in;
   logic              formatted_ff, formatted_in;
   status_type        dstat_ff, dstat_in;
   logic [SIZE_W-1:0] dpos_ff, dpos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [WORD_W-1:0] size_w;
   logic [CNT_W-1:0]  cnt_nx;
   logic              walk_end;
   logic [WORD_W+1:0] grow_sum;
   logic [WORD_W-1:0] spare;

   assign size_w = {{(WORD_W - SIZE_W){1'b0}}, size_ff};
   assign cnt_nx = cnt_ff + CNT_W'(1);
   assign walk_end = cnt_nx == CNT_W'(WALK_LIMIT);
   assign grow_sum = {2'b00, sz_ff} + {2'b00, HDR_BYTES} + {2'b00, mem_rdata};
   assign spare = bs_ff - size_w;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rover_ff <= FIRST_HDR;
         formatted_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rover_ff <= rover_in;
         formatted_ff <= formatted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff <= ctx_in;
      kind_ff <= kind_in;
      size_ff <= size_in;
      pos_ff <= pos_in;
      hdr_ff <= hdr_in;
      walk_ff <= walk_in;
      sp_ff <= sp_in;
      ab_ff <= ab_in;
      n_ff <= n_in;
      p_ff <= p_in;
      an_ff <= an_in;
      ann_ff <= ann_in;
      sz_ff <= sz_in;
      bs_ff <= bs_in;
      sn_ff <= sn_in;
      t_ff <= t_in;
      cnt_ff <= cnt_in;
      fit_ff <= fit_in;
      ok_ff <= ok_in;
      res_ff <= res_in;
      dstat_ff <= dstat_in;
      dpos_ff <= dpos_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in = state_ff;
      ctx_in = ctx_ff;
      kind_in = kind_ff;
      size_in = size_ff;
      pos_in = pos_ff;
      hdr_in = hdr_ff;
      walk_in = walk_ff;
      sp_in = sp_ff;
      ab_in = ab_ff;
      n_in = n_ff;
      p_in = p_ff;
      an_in = an_ff;
      ann_in = ann_ff;
      sz_in = sz_ff;
      bs_in = bs_ff;
      sn_in = sn_ff;
      t_in = t_ff;
      cnt_in = cnt_ff;
      fit_in = fit_ff;
      ok_in = ok_ff;
      res_in = res_ff;
      rover_in = rover_ff;
      formatted_in = formatted_ff;
      dstat_in = dstat_ff;
      dpos_in = dpos_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in = rsp_data_ff;
      mem_req.we = 1'b0;
      mem_req.addr = '0;
      mem_req.wdata = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_data.kind;
               size_in = req_data.req_size;
               pos_in = req_data.position;
               hdr_in = {{(WORD_W - SIZE_W){1'b0}}, req_data.position} - HDR_BYTES;
               if (req_data.kind == KIND_FORMAT) begin
                  state_in = ST_FMT0;
               end else if (!formatted_ff) begin
                  dstat_in = STATUS_NOT_FMT;
                  dpos_in = '0;
                  state_in = ST_DONE;
               end else if (req_data.kind == KIND_ALLOC) begin
                  walk_in = rover_ff;
                  cnt_in = '0;
                  ctx_in = CTX_ALLOC;
                  state_in = ST_A0;
               end else begin
                  state_in = ST_V0;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = dstat_ff;
               rsp_data_in.out_position = dpos_ff;
               state_in = ST_IDLE;
            end
         end
         ST_FMT0: begin
            mem_req.we = 1'b1;
            mem_req.addr = at(FIRST_HDR, 4'd0);
            mem_req.wdata = MARK_FREE;
            state_in = ST_FMT1;
         end
         ST_FMT1: begin
            mem_req.we = 1'b1;
            mem_req.addr = at(FIRST_HDR, 4'd2);
            mem_req.wdata = format_size;
            state_in = ST_FMT2;
         end
         ST_FMT2: begin
            mem_req.we = 1'b1;
            mem_req.addr = at(FIRST_HDR, 4'd4);
            mem_req.wdata = '0;
            state_in = ST_FMT3;
         end
         ST_FMT3: begin
            mem_req.we = 1'b1;
            mem_req.addr = at(FIRST_HDR, 4'd6);
            mem_req.wdata = FIRST_HDR;
            rover_in = FIRST_HDR;
            formatted_in = 1'b1;
            dstat_in = STATUS_OK;
            dpos_in = '0;
            state_in = ST_DONE;
         end
         ST_V0: begin
            if (pos_ff < SIZE_W'(HDR_BYTES + FIRST_HDR)) begin
               ok_in = 1'b0;
               state_in = ST_BR;
            end else begin
               walk_in = FIRST_HDR;
               cnt_in = '0;
               state_in = ST_VC;
            end
         end
         ST_VC: begin
            if (walk_ff == hdr_ff) begin
               mem_req.addr = at(walk_ff, 4'd0);
               state_in = ST_VM;
            end else begin
               mem_req.addr = at(walk_ff, 4'd6);
               state_in = ST_VN;
            end
         end
         ST_VM: begin
            ok_in = mem_rdata == MARK_USED;
            state_in = ST_BR;
         end
         ST_VN: begin
            walk_in = mem_rdata;
            cnt_in = cnt_nx;
            if (mem_rdata == FIRST_HDR || walk_end) begin
               ok_in = 1'b0;
               state_in = ST_BR;
            end else begin
               state_in = ST_VC;
            end
         end
         ST_BR: begin
            if (kind_ff == KIND_FREE) begin
               if (ok_ff) begin
                  state_in = ST_FR0;
               end else begin
                  dstat_in = STATUS_OK;
                  dpos_in = '0;
                  state_in = ST_DONE;
               end
            end else if (!ok_ff) begin
               dstat_in = STATUS_NO_SPACE;
               dpos_in = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_R0;
            end
         end
         ST_R0: begin
            mem_req.addr = at(hdr_ff, 4'd2);
            state_in = ST_R1;
         end
         ST_R1: begin
            sz_in = mem_rdata;
            if (mem_rdata >= size_w) begin
               dstat_in = STATUS_OK;
               dpos_in = pos_ff;
               state_in = ST_DONE;
            end else begin
               mem_req.addr = at(hdr_ff, 4'd6);
               state_in = ST_R2;
            end
         end
         ST_R2: begin
            n_in = mem_rdata;
            if (mem_rdata == FIRST_HDR) begin
               walk_in = rover_ff;
               cnt_in = '0;
               ctx_in = CTX_ALLOC;
               state_in = ST_A0;
            end else begin
               mem_req.addr = at(mem_rdata, 4'd0);
               state_in = ST_R3;
            end
         end
         ST_R3: begin
            if (mem_rdata != MARK_FREE) begin
               walk_in = rover_ff;
               cnt_in = '0;
               ctx_in = CTX_ALLOC;
               state_in = ST_A0;
            end else begin
               mem_req.addr = at(n_ff, 4'd2);
               state_in = ST_R4;
            end
         end
         ST_R4: begin
            if (grow_sum >= {2'b00, size_w}) begin
               ab_in = hdr_ff;
               ctx_in = CTX_GROW;
               state_in = ST_AB0;
            end else begin
               walk_in = rover_ff;
               cnt_in = '0;
               ctx_in = CTX_ALLOC;
               state_in = ST_A0;
            end
         end
         ST_A0: begin
            mem_req.addr = at(walk_ff, 4'd0);
            state_in = ST_A1;
         end
         ST_A1: begin
            fit_in = mem_rdata == MARK_FREE;
            mem_req.addr = at(walk_ff, 4'd2);
            state_in = ST_A2;
         end
         ST_A2: begin
            fit_in = fit_ff & (mem_rdata >= size_w);
            mem_req.addr = at(walk_ff, 4'd6);
            state_in = ST_A3;
         end
         ST_A3: begin
            if (fit_ff) begin
               mem_req.we = 1'b1;
               mem_req.addr = at(walk_ff, 4'd0);
               mem_req.wdata = MARK_USED;
               sp_in = walk_ff;
               state_in = ST_S0;
            end else if (mem_rdata == rover_ff || walk_end) begin
               dstat_in = STATUS_NO_SPACE;
               dpos_in = '0;
               state_in = ST_DONE;
            end else begin
               walk_in = mem_rdata;
               cnt_in = cnt_nx;
               state_in = ST_A0;
            end
         end
         ST_S0: begin
            mem_req.addr = at(sp_ff, 4'd2);
            state_in = ST_S1;
         end
         ST_S1: begin
            bs_in = mem_rdata;
            mem_req.addr = at(sp_ff, 4'd6);
            state_in = ST_S2;
         end
         ST_S2: begin
            sn_in = mem_rdata;
            if (bs_ff >= size_w && spare >= MIN_SPLIT) begin
               t_in = at(sp_ff, 4'd8) + {{(ADDR_W - SIZE_W){1'b0}}, size_ff};
               mem_req.we = 1'b1;
               mem_req.addr = at(sp_ff, 4'd8) + {{(ADDR_W - SIZE_W){1'b0}}, size_ff};
               mem_req.wdata = MARK_FREE;
               state_in = ST_S3;
            end else begin
               state_in = ST_SRET;
            end
         end
         ST_S3: begin
            mem_req.we = 1'b1;
            mem_req.addr = t_ff + ADDR_W'(2);
            mem_req.wdata = spare - HDR_BYTES;
            state_in = ST_S4;
         end
         ST_S4: begin
            mem_req.we = 1'b1;
            mem_req.addr = t_ff + ADDR_W'(4);
            mem_req.wdata = sp_ff;
            state_in = ST_S5;
         end
         ST_S5: begin
            mem_req.we = 1'b1;
            mem_req.addr = t_ff + ADDR_W'(6);
            mem_req.wdata = sn_ff;
            state_in = ST_S6;
         end
         ST_S6: begin
            mem_req.we = sn_ff != FIRST_HDR;
            mem_req.addr = at(sn_ff, 4'd4);
            mem_req.wdata = t_ff[WORD_W-1:0];
            state_in = ST_S7;
         end
         ST_S7: begin
            mem_req.we = 1'b1;
            mem_req.addr = at(sp_ff, 4'd2);
            mem_req.wdata = size_w;
            state_in = ST_S8;
         end
         ST_S8: begin
            mem_req.we = 1'b1;
            mem_req.addr = at(sp_ff, 4'd6);
            mem_req.wdata = t_ff[WORD_W-1:0];
            state_in = ST_SRET;
         end
         ST_SRET: begin
            mem_req.addr = at(sp_ff, 4'd6);
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (ctx_ff == CTX_ALLOC) begin
               rover_in = mem_rdata;
               res_in = sp_ff[SIZE_W-1:0] + SIZE_W'(HDR_BYTES);
               if (kind_ff == KIND_ALLOC) begin
                  dstat_in = STATUS_OK;
                  dpos_in = sp_ff[SIZE_W-1:0] + SIZE_W'(HDR_BYTES);
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FR0;
               end
            end else begin
               if (rover_ff == n_ff) begin
                  rover_in = mem_rdata;
               end
               dstat_in = STATUS_OK;
               dpos_in = pos_ff;
               state_in = ST_DONE;
            end
         end
         ST_FR0: begin
            mem_req.we = 1'b1;
            mem_req.addr = at(hdr_ff, 4'd0);
            mem_req.wdata = MARK_FREE;
            state_in = ST_FR1;
         end
         ST_FR1: begin
            mem_req.addr = at(hdr_ff, 4'd6);
            state_in = ST_FR2;
         end
         ST_FR2: begin
            n_in = mem_rdata;
            if (mem_rdata != FIRST_HDR) begin
               mem_req.addr = at(mem_rdata, 4'd0);
               state_in = ST_FR3;
            end else begin
               state_in = ST_FP0;
            end
         end
         ST_FR3: begin
            if (mem_rdata == MARK_FREE) begin
               ab_in = hdr_ff;
               ctx_in = CTX_FREE_NEXT;
               state_in = ST_AB0;
            end else begin
               state_in = ST_FP0;
            end
         end
         ST_FP0: begin
            mem_req.addr = at(hdr_ff, 4'd4);
            state_in = ST_FP1;
         end
         ST_FP1: begin
            p_in = mem_rdata;
            if (mem_rdata != '0) begin
               mem_req.addr = at(mem_rdata, 4'd0);
               state_in = ST_FP2;
            end else begin
               state_in = ST_FE;
            end
         end
         ST_FP2: begin
            if (mem_rdata == MARK_FREE) begin
               ab_in = p_ff;
               ctx_in = CTX_FREE_PREV;
               state_in = ST_AB0;
            end else begin
               state_in = ST_FE;
            end
         end
         ST_FE: begin
            dstat_in = STATUS_OK;
            dpos_in = (kind_ff == KIND_RESIZE) ? res_ff : '0;
            state_in = ST_DONE;
         end
         ST_AB0: begin
            mem_req.addr = at(ab_ff, 4'd6);
            state_in = ST_AB1;
         end
         ST_AB1: begin
            an_in = mem_rdata;
            mem_req.addr = at(mem_rdata, 4'd6);
            state_in = ST_AB2;
         end
         ST_AB2: begin
            ann_in = mem_rdata;
            mem_req.addr = at(ab_ff, 4'd2);
            state_in = ST_AB3;
         end
         ST_AB3: begin
            sz_in = mem_rdata;
            mem_req.addr = at(an_ff, 4'd2);
            state_in = ST_AB4;
         end
         ST_AB4: begin
            mem_req.we = 1'b1;
            mem_req.addr = at(ab_ff, 4'd2);
            mem_req.wdata = grow_sum[WORD_W-1:0];
            state_in = ST_AB5;
         end
         ST_AB5: begin
            mem_req.we = 1'b1;
            mem_req.addr = at(ab_ff, 4'd6);
            mem_req.wdata = ann_ff;
            state_in = ST_AB6;
         end
         ST_AB6: begin
            mem_req.we = ann_ff != FIRST_HDR;
            mem_req.addr = at(ann_ff, 4'd4);
            mem_req.wdata = ab_ff;
            unique case (ctx_ff)
               CTX_FREE_NEXT: begin
                  if (rover_ff == n_ff) begin
                     rover_in = hdr_ff;
                  end
                  state_in = ST_FP0;
               end
               CTX_FREE_PREV: begin
                  if (rover_ff == hdr_ff) begin
                     rover_in = p_ff;
                  end
                  state_in = ST_FE;
               end
               CTX_GROW: begin
                  sp_in = hdr_ff;
                  state_in = ST_S0;
               end
               default: begin
                  state_in = ST_FE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the completion state");

   a_formatted_sticks: assert property (@(posedge clock) disable iff (reset)
      formatted_ff |=> formatted_ff)
      else $error("formatted flag dropped");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DONE) |-> !mem_req.we)
      else $error("arena write while no request is in progress");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A0 || state_ff == ST_VC) |-> cnt_ff < CNT_W'(WALK_LIMIT))
      else $error("chain walk exceeded its bound");

   a_not_fmt_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && dstat_ff == STATUS_NOT_FMT) |-> !formatted_ff)
      else $error("not-formatted status on a formatted arena");
`endif

endmodule

// ===== rtl/core/next_fit_arena_allocator_unit.sv =====
// Next-fit arena allocator with coalescing over a byte arena held in block RAM.
// Channels: req_* carries one request (kind, req_size, position) per transfer;
// rsp_* returns exactly one result (status, out_position) per request, in order;
// csr_* writes the arena size used by format and is always ready.
// A request is taken only when the sequencer is idle; the result sits in an
// output register, so the next request is taken while it waits for the receiver.
// A stalled receiver holds the result and, once another request has finished,
// also holds the sequencer until the register drains.
// Format writes the four header words of the first block; a request on an
// unformatted arena is answered without touching the arena. Allocate reads each
// block header walked from the rover, then marks, splits and moves the rover.
// Free and resize first walk the chain from the first block to check the position,
// then merge free neighbors. Each header access is one read or write of a 16-bit
// word through the arena store's single request port with a registered read,
// which sets the rate.
// Reset clears the formatted flag and the output valid flag, sets the rover to the
// first block and loads the arena size register with 4096; arena RAM is not cleared.
// Uses nfa_pkg, nfa_ctrl and nfa_store.
module next_fit_arena_allocator_unit #(
   parameter int ARENA_BYTES = nfa_pkg::ARENA_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  nfa_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output nfa_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [nfa_pkg::CSR_W-1:0] csr_data
);
   import nfa_pkg::*;

   logic [CSR_W-1:0]  arena_bytes_ff, arena_bytes_in;
   logic [WORD_W-1:0] csr_word;
   logic [WORD_W-1:0] eff_bytes;
   logic [WORD_W-1:0] format_size;
   mem_req_type       mem_req;
   logic [WORD_W-1:0] mem_rdata;

   assign csr_ready = 1'b1;
   assign arena_bytes_in = (csr_valid && csr_ready) ? csr_data : arena_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_bytes_ff <= CSR_RESET;
      end else begin
         arena_bytes_ff <= arena_bytes_in;
      end
   end

   assign csr_word = {{(WORD_W - CSR_W){1'b0}}, arena_bytes_ff};

   always_comb begin
      if (csr_word < MIN_ARENA) begin
         eff_bytes = MIN_ARENA;
      end else if (csr_word > WORD_W'(ARENA_BYTES)) begin
         eff_bytes = WORD_W'(ARENA_BYTES);
      end else begin
         eff_bytes = csr_word;
      end
   end

   assign format_size = eff_bytes - FIRST_HDR - HDR_BYTES;

   nfa_ctrl #(.ARENA_BYTES(ARENA_BYTES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .format_size (format_size),
      .mem_req     (mem_req),
      .mem_rdata   (mem_rdata)
   );

   nfa_store #(.ARENA_BYTES(ARENA_BYTES)) u_store (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

endmodule
